// ===== hw/rtl/hsp_pkg.sv =====
package hsp_pkg;

  // Transmit FIFO geometry
  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int LEVEL_W    = 11;

  // Command queue between front and back
  localparam int CQ_DEPTH   = 2;
  localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W   = $clog2(CQ_DEPTH + 1);

  // Input command codes
  localparam logic CMD_QUEUE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Classified operation
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_MASTER_RX,
    OP_MASTER_TX,
    OP_OTHER
  } op_t;

  // Classified item: data is the queued byte or the sampled bus byte
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } req_t;

  // One result item
  typedef struct packed {
    logic               ready_level;
    logic               flag_drive;
    logic               flag_level;
    logic               bus_drive;
    logic [7:0]         bus_out;
    logic               got_valid;
    logic [7:0]         got_byte;
    logic               overflow;
    logic [LEVEL_W-1:0] queue_level;
  } res_t;

endpackage

// ===== hw/rtl/hsp_ram.sv =====
module hsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/hsp_front.sv =====
module hsp_front import hsp_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       command,
  input  logic [7:0] queue_byte,
  input  logic       mode_pin_zero,
  input  logic       mode_pin_one,
  input  logic [7:0] bus_in,
  input  logic       q_full,
  output logic       q_push,
  output req_t       q_item
);

  // Accept while the command queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the item: decode the mode pins on a tick
  always_comb begin
    q_item.op   = OP_PUSH;
    q_item.data = queue_byte;
    if (command == CMD_TICK) begin
      q_item.data = bus_in;
      if (mode_pin_zero && !mode_pin_one) begin
        q_item.op = OP_MASTER_RX;
      end else if (!mode_pin_zero && mode_pin_one) begin
        q_item.op = OP_MASTER_TX;
      end else begin
        q_item.op = OP_OTHER;
      end
    end
  end

endmodule

// ===== hw/rtl/hsp_cmd_queue.sv =====
module hsp_cmd_queue import hsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_item,
  output logic full,
  input  logic pop,
  output logic valid,
  output req_t head_item
);

  req_t                entries [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr;
  logic [CQ_PTR_W-1:0] rd_ptr;
  logic [CQ_CNT_W-1:0] fill;

  assign full      = (fill == CQ_CNT_W'(CQ_DEPTH));
  assign valid     = (fill != '0);
  assign head_item = entries[rd_ptr];

  // Hold payload entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/hsp_back.sv =====
module hsp_back import hsp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  req_t q_item,
  output logic q_pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TX,
    PH_RX
  } phase_t;

  state_t             state, state_next;
  phase_t             phase, phase_next;
  logic [PTR_W-1:0]   head, head_next;
  logic [PTR_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   count, count_next;
  logic               ready_reg, ready_reg_next;
  logic               flag_drv, flag_drv_next;
  logic               flag_lvl, flag_lvl_next;
  logic               bus_drv, bus_drv_next;
  logic [7:0]         bus_val, bus_val_next;
  logic               res_valid;
  res_t               res_next;
  logic               res_load;
  logic               out_free;
  logic               got_valid_v;
  logic [7:0]         got_byte_v;
  logic               overflow_v;
  logic               ram_we;
  logic               ram_re;
  logic [7:0]         ram_rdata;

  hsp_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail),
    .wdata (q_item.data),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  assign out_free  = !res_valid || out_ready;
  assign out_valid = res_valid;

  // Carry out one item; a pop waits in S_READ for the registered head byte
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    ready_reg_next = ready_reg;
    flag_drv_next  = flag_drv;
    flag_lvl_next  = flag_lvl;
    bus_drv_next   = bus_drv;
    bus_val_next   = bus_val;
    got_valid_v    = 1'b0;
    got_byte_v     = '0;
    overflow_v     = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    q_pop          = 1'b0;
    res_load       = 1'b0;

    case (state)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop    = 1'b1;
          res_load = 1'b1;
          if (q_item.op == OP_PUSH) begin
            // Append, or drop on a full FIFO
            if (count == CNT_W'(FIFO_DEPTH)) begin
              overflow_v = 1'b1;
            end else begin
              ram_we     = 1'b1;
              tail_next  = (tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
              count_next = count + 1'b1;
            end
          end else begin
            case (phase)
              PH_TX: begin
                // Release once the master leaves receive mode
                if (q_item.op != OP_MASTER_RX) begin
                  ready_reg_next = 1'b0;
                  flag_drv_next  = 1'b0;
                  flag_lvl_next  = 1'b0;
                  bus_drv_next   = 1'b0;
                  bus_val_next   = '0;
                  phase_next     = PH_IDLE;
                end
              end
              PH_RX: begin
                // Release once the master leaves send mode
                if (q_item.op != OP_MASTER_TX) begin
                  ready_reg_next = 1'b0;
                  flag_drv_next  = 1'b0;
                  flag_lvl_next  = 1'b0;
                  bus_drv_next   = 1'b0;
                  bus_val_next   = '0;
                  phase_next     = PH_IDLE;
                end
              end
              default: begin
                phase_next = PH_IDLE;
                if (q_item.op == OP_MASTER_RX) begin
                  flag_drv_next  = 1'b1;
                  ready_reg_next = 1'b1;
                  phase_next     = PH_TX;
                  if (count == '0) begin
                    flag_lvl_next = 1'b0;
                  end else begin
                    // Pop the head byte; result waits for read data
                    flag_lvl_next = 1'b1;
                    bus_drv_next  = 1'b1;
                    ram_re        = 1'b1;
                    head_next     = (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
                    count_next    = count - 1'b1;
                    res_load      = 1'b0;
                    state_next    = S_READ;
                  end
                end else if (q_item.op == OP_MASTER_TX) begin
                  got_valid_v    = 1'b1;
                  got_byte_v     = q_item.data;
                  ready_reg_next = 1'b1;
                  phase_next     = PH_RX;
                end
              end
            endcase
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          bus_val_next = ram_rdata;
          res_load     = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    res_next.ready_level = ready_reg_next;
    res_next.flag_drive  = flag_drv_next;
    res_next.flag_level  = flag_lvl_next;
    res_next.bus_drive   = bus_drv_next;
    res_next.bus_out     = bus_val_next;
    res_next.got_valid   = got_valid_v;
    res_next.got_byte    = got_byte_v;
    res_next.overflow    = overflow_v;
    res_next.queue_level = LEVEL_W'(count_next);
  end

  // Hold state, pin registers and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      ready_reg <= 1'b0;
      flag_drv  <= 1'b0;
      flag_lvl  <= 1'b0;
      bus_drv   <= 1'b0;
      bus_val   <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      ready_reg <= ready_reg_next;
      flag_drv  <= flag_drv_next;
      flag_lvl  <= flag_lvl_next;
      bus_drv   <= bus_drv_next;
      bus_val   <= bus_val_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (res_load) begin
      res <= res_next;
    end
  end

endmodule

// ===== hw/rtl/parallel_handshake_port_with_tx_fifo.sv =====
// Slave side of an 8-bit parallel handshake link with a 1024-byte transmit
// FIFO. Each input item is either a queue item (command 0, append
// queue_byte) or a tick (command 1, sample the mode pins and bus_in), and
// each gives exactly one result showing the pin registers after it. The
// front decodes the mode pins and places the item in a two-entry command
// queue; in_ready is high while that queue has room. The back executes one
// item per cycle while its result can be taken, but a tick that pops a byte
// from the FIFO also waits in a read state: the FIFO memory has a registered
// read port. Results sit in an output register, so the back keeps going
// while out_ready is high and the front keeps accepting until the command
// queue fills. A full FIFO drops the byte and sets overflow on that result.
module parallel_handshake_port_with_tx_fifo import hsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [7:0]         queue_byte,
  input  logic               mode_pin_zero,
  input  logic               mode_pin_one,
  input  logic [7:0]         bus_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ready_level,
  output logic               flag_drive,
  output logic               flag_level,
  output logic               bus_drive,
  output logic [7:0]         bus_out,
  output logic               got_valid,
  output logic [7:0]         got_byte,
  output logic               overflow,
  output logic [LEVEL_W-1:0] queue_level
);

  logic q_full;
  logic q_push;
  req_t q_in_item;
  logic q_pop;
  logic q_valid;
  req_t q_head_item;
  res_t res;

  hsp_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .queue_byte    (queue_byte),
    .mode_pin_zero (mode_pin_zero),
    .mode_pin_one  (mode_pin_one),
    .bus_in        (bus_in),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in_item)
  );

  hsp_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_item (q_head_item)
  );

  hsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Unpack the result register onto the ports
  assign ready_level = res.ready_level;
  assign flag_drive  = res.flag_drive;
  assign flag_level  = res.flag_level;
  assign bus_drive   = res.bus_drive;
  assign bus_out     = res.bus_out;
  assign got_valid   = res.got_valid;
  assign got_byte    = res.got_byte;
  assign overflow    = res.overflow;
  assign queue_level = res.queue_level;

endmodule
